// ===== rtl/core/binero_pkg.sv =====
// ----------------------------------------------------------------------------
// binero_pkg
// Shared constants and types for the 3x3 binary erosion stream block.
// ----------------------------------------------------------------------------
package binero_pkg;

	// Image limits
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;

	// Field and register widths
	localparam int PIX_W      = 8;
	localparam int CNT_W      = 23;
	localparam int WID_W      = 11;
	localparam int HGT_W      = 13;
	localparam int ROW_W      = HGT_W;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int OUT_DATA_W = ((PIX_W + CNT_W + 7) / 8) * 8;
	localparam int LINE_W     = PIX_W + 1;

	localparam logic [CNT_W-1:0] COUNT_MAX = '1;

	// Register reset values
	localparam logic [WID_W-1:0] WIDTH_RST  = WID_W'(640);
	localparam logic [HGT_W-1:0] HEIGHT_RST = HGT_W'(480);

	// Stream command carried on s_tuser
	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1,
		REG_EIGHT_CONN   = 2'd2
	} cfg_reg_t;

	// One window column: set bit above, center value, set bit below
	typedef struct packed {
		logic             up;
		logic [PIX_W-1:0] mid;
		logic             down;
	} column_t;

	// Position flags and data carried from the input register to the result stage
	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [PIX_W-1:0] px;
		logic             has_res;
		logic             last;
		logic             at_top;
		logic             at_bottom;
		logic             at_left;
		logic             at_right;
	} stage1_t;

endpackage

// ===== rtl/core/binero_ram.sv =====
// ----------------------------------------------------------------------------
// binero_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module binero_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/core/binary_erosion_3x3.sv =====
// ----------------------------------------------------------------------------
// binary_erosion_3x3
// Streaming 3x3 binary erosion, 4- or 8-connected, with removed pixel count.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle on input and output while m_tready stays high.
// Latency: a result is due image_width+1 items after its source pixel; the
//   item that completes it enters stage 1 at its accepting edge (line store
//   read at that edge); evaluation loads the output register as stage 1 moves on.
// Reset: arst_n clears counters, window, count, valids and registers to their
//   defaults; line store contents stay undefined and are not cleared.
// ----------------------------------------------------------------------------
module binary_erosion_3x3 (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [binero_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [binero_pkg::CFG_DATA_W-1:0]   cfg_data,
	// input stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [binero_pkg::PIX_W-1:0]        s_tdata,  // [7:0] pixel_in
	input  logic                                s_tuser,  // [0] cmd (1 = flush tick)
	// output stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [binero_pkg::OUT_DATA_W-1:0]   m_tdata,  // [7:0] pixel_out, [30:8] removed_count
	output logic                                m_tlast   // frame_done
);

	// ------------------------------------------------------------------
	// Configuration registers; writes are always taken.
	// ------------------------------------------------------------------
	logic [binero_pkg::WID_W-1:0] width_q;
	logic [binero_pkg::HGT_W-1:0] height_q;
	logic                         eight_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= binero_pkg::WIDTH_RST;
			height_q <= binero_pkg::HEIGHT_RST;
			eight_q  <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				binero_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data[binero_pkg::WID_W-1:0];
				binero_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data[binero_pkg::HGT_W-1:0];
				binero_pkg::REG_EIGHT_CONN:   eight_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Effective size: zero acts as one, oversize clamps to the maximum.
	logic [binero_pkg::WID_W-1:0] w_eff;
	logic [binero_pkg::HGT_W-1:0] h_eff;

	always_comb begin
		if (width_q == '0) begin
			w_eff = binero_pkg::WID_W'(1);
		end else if (int'(width_q) > binero_pkg::MAX_WIDTH) begin
			w_eff = binero_pkg::WID_W'(binero_pkg::MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		if (height_q == '0) begin
			h_eff = binero_pkg::HGT_W'(1);
		end else if (int'(height_q) > binero_pkg::MAX_HEIGHT) begin
			h_eff = binero_pkg::HGT_W'(binero_pkg::MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
	end

	// ------------------------------------------------------------------
	// Accept side: position of the incoming item and of the result it
	// completes. All of this depends on counters only, so it is settled
	// before the line store data comes back.
	// ------------------------------------------------------------------
	logic [binero_pkg::COL_W-1:0] col_q;
	logic [binero_pkg::ROW_W-1:0] row_q;

	logic                         s1_valid_q;
	binero_pkg::stage1_t          s1_q;
	logic                         s1_adv;

	logic                         wrap;
	logic [binero_pkg::COL_W-1:0] ic;
	logic [binero_pkg::ROW_W-1:0] ir;
	logic                         draining;
	logic                         skip;
	logic                         acc;
	logic                         load_s1;
	logic [binero_pkg::WID_W-1:0] col_inc;
	logic                         has_res;
	logic [binero_pkg::ROW_W-1:0] orow;
	logic [binero_pkg::WID_W-1:0] ocol;
	logic [binero_pkg::ROW_W-1:0] h_last;
	logic [binero_pkg::WID_W-1:0] w_last;
	logic                         is_last;

	// Stage 1 can move on when it carries no result or the output slot frees.
	assign s1_adv   = s1_valid_q && (!s1_q.has_res || !m_tvalid || m_tready);
	assign s_tready = !s1_valid_q || s1_adv;
	assign acc      = s_tvalid && s_tready;

	always_comb begin
		// column beyond the width (only after a width change) wraps to next row
		wrap     = binero_pkg::WID_W'(col_q) >= w_eff;
		ic       = wrap ? '0 : col_q;
		ir       = wrap ? row_q + binero_pkg::ROW_W'(1) : row_q;
		draining = ir >= h_eff;
		// flush while pixels are still expected does nothing
		skip     = !draining && (s_tuser == binero_pkg::CMD_FLUSH);
		load_s1  = acc && !skip;
		col_inc  = binero_pkg::WID_W'(ic) + binero_pkg::WID_W'(1);

		// warm-up: first row and first pixel of the second row give no result
		has_res  = !((ir == '0) || (ir == binero_pkg::ROW_W'(1) && ic == '0));
		h_last   = h_eff - binero_pkg::HGT_W'(1);
		w_last   = w_eff - binero_pkg::WID_W'(1);
		if (ic != '0) begin
			orow = ir - binero_pkg::ROW_W'(1);
			ocol = binero_pkg::WID_W'(ic) - binero_pkg::WID_W'(1);
		end else begin
			orow = ir - binero_pkg::ROW_W'(2);
			ocol = w_last;
		end
		is_last  = has_res && ((orow > h_last) || (orow == h_last && ocol >= w_last));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (skip) begin
				col_q <= ic;
				row_q <= ir;
			end else if (is_last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_inc >= w_eff) begin
				col_q <= '0;
				row_q <= ir + binero_pkg::ROW_W'(1);
			end else begin
				col_q <= col_inc[binero_pkg::COL_W-1:0];
				row_q <= ir;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (load_s1) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			s1_q.col       <= ic;
			s1_q.px        <= draining ? '0 : s_tdata;
			s1_q.has_res   <= has_res;
			s1_q.last      <= is_last;
			s1_q.at_top    <= orow == '0;
			s1_q.at_bottom <= orow >= h_last;
			s1_q.at_left   <= ocol == '0;
			s1_q.at_right  <= ocol >= w_last;
		end
	end

	// ------------------------------------------------------------------
	// Line store: {upper set bit, center pixel} per column, one RAM.
	// Read at accept, written back when stage 1 moves on.
	// ------------------------------------------------------------------
	logic [binero_pkg::LINE_W-1:0] ram_rd;
	logic [binero_pkg::LINE_W-1:0] ram_wr;
	logic [binero_pkg::LINE_W-1:0] line;
	logic                          fwd_q;
	logic [binero_pkg::LINE_W-1:0] fwd_data_q;

	binero_ram #(
		.WIDTH (binero_pkg::LINE_W),
		.DEPTH (binero_pkg::MAX_WIDTH)
	) u_line_ram (
		.clk     (clk),
		.wr_en   (s1_adv),
		.wr_addr (s1_q.col),
		.wr_data (ram_wr),
		.rd_en   (load_s1),
		.rd_addr (ic),
		.rd_data (ram_rd)
	);

	// One-pixel rows read the column that is written in the same cycle:
	// bypass the write data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (load_s1) begin
			fwd_q <= s1_adv && (s1_q.col == ic);
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			fwd_data_q <= ram_wr;
		end
	end

	assign line   = fwd_q ? fwd_data_q : ram_rd;
	assign ram_wr = {(line[binero_pkg::PIX_W-1:0] != '0), s1_q.px};

	// ------------------------------------------------------------------
	// Stage 1: window shift and erosion decision.
	// win_left_q and win_mid_q hold the columns that become left and middle
	// once the new column is shifted in.
	// ------------------------------------------------------------------
	binero_pkg::column_t          win_left_q;
	binero_pkg::column_t          win_mid_q;
	binero_pkg::column_t          nc;
	logic                         keep_all;
	logic                         cur_set;
	logic                         inc;
	logic [binero_pkg::CNT_W-1:0] removed_q;
	logic [binero_pkg::CNT_W-1:0] rem_next;
	logic [binero_pkg::PIX_W-1:0] pix_res;

	always_comb begin
		nc.up   = line[binero_pkg::PIX_W];
		nc.mid  = line[binero_pkg::PIX_W-1:0];
		nc.down = s1_q.px != '0;

		// neighbours outside the image count as set
		keep_all = (s1_q.at_top || win_mid_q.up) &&
			(s1_q.at_bottom || win_mid_q.down) &&
			(s1_q.at_left || win_left_q.mid != '0) &&
			(s1_q.at_right || nc.mid != '0);
		if (eight_q) begin
			keep_all = keep_all &&
				(s1_q.at_top || s1_q.at_left || win_left_q.up) &&
				(s1_q.at_top || s1_q.at_right || nc.up) &&
				(s1_q.at_bottom || s1_q.at_left || win_left_q.down) &&
				(s1_q.at_bottom || s1_q.at_right || nc.down);
		end

		cur_set  = win_mid_q.mid != '0;
		pix_res  = (cur_set && keep_all) ? win_mid_q.mid : '0;
		// saturating removed count
		inc      = s1_q.has_res && cur_set && !keep_all && (removed_q != binero_pkg::COUNT_MAX);
		rem_next = removed_q + binero_pkg::CNT_W'(inc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_left_q <= '0;
			win_mid_q  <= '0;
			removed_q  <= '0;
		end else if (s1_adv) begin
			if (s1_q.last) begin
				win_left_q <= '0;
				win_mid_q  <= '0;
			end else begin
				win_left_q <= win_mid_q;
				win_mid_q  <= nc;
			end
			if (s1_q.has_res) begin
				removed_q <= s1_q.last ? '0 : rem_next;
			end
		end
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	logic [binero_pkg::PIX_W-1:0] pix_s2;
	logic [binero_pkg::CNT_W-1:0] cnt_s2;
	logic                         last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (s1_adv && s1_q.has_res) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_q.has_res) begin
			pix_s2  <= pix_res;
			cnt_s2  <= s1_q.last ? rem_next : '0;
			last_s2 <= s1_q.last;
		end
	end

	assign m_tdata = {{(binero_pkg::OUT_DATA_W - binero_pkg::PIX_W - binero_pkg::CNT_W){1'b0}},
		cnt_s2, pix_s2};
	assign m_tlast = last_s2;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_count_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |->
		m_tdata[binero_pkg::PIX_W+binero_pkg::CNT_W-1:binero_pkg::PIX_W] == '0)
		else $error("removed_count nonzero on a result that does not end the image");

	a_no_accept_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !s1_adv |-> !s_tready)
		else $error("input accepted while stage 1 is stalled");

	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && s1_q.last |=> removed_q == '0 && win_mid_q == '0 && win_left_q == '0)
		else $error("count or window not cleared after end of image");

endmodule
